### rtl/baro_temp_pressure_compensation_macros.svh
// Assertion macros shared by the checker of the compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// Same-cycle implication under reset.
`define BTPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btpc assertion failed");

// Next-cycle implication under reset.
`define BTPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btpc assertion failed");

`endif

### rtl/btpc_pkg.sv
// Types, constants and helper functions of the compensation block.
package btpc_pkg;

   localparam int unsigned CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CAL_TEMP    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CAL_PRESS_A = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CAL_PRESS_B = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CAL_P9      = 2'd3;

   localparam logic [63:0] FINE_OFFSET = 64'd128000;
   localparam logic [63:0] PRESS_BASE  = 64'd1048576;
   localparam logic [63:0] SCALE_3125  = 64'd3125;
   localparam logic [63:0] SCALE_1000  = 64'd1000;
   localparam logic [31:0] TEMP_ROUND  = 32'd128;
   localparam logic [63:0] ONE_47      = 64'd1 << 47;

   typedef enum logic [3:0] {
      STEP_T0, STEP_T1, STEP_T2,
      STEP_P0, STEP_P1, STEP_P2, STEP_P3, STEP_P4, STEP_P5, STEP_P6,
      STEP_DIV,
      STEP_P7, STEP_P8, STEP_P9, STEP_P10
   } step_type;

   typedef struct packed {
      logic     load;
      logic     mul_start;
      logic     mul_wb;
      logic     div_start;
      logic     div_wb;
      logic     out_load;
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic den_zero;
   } status_type;

   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
      return 64'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] sx16(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

endpackage

### rtl/btpc_if.sv
// Request and response channel interfaces of the compensation block.
interface btpc_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [19:0] raw_sample;
   modport source (output valid, output kind, output raw_sample, input ready);
   modport sink   (input valid, input kind, input raw_sample, output ready);
endinterface

interface btpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [32:0] value;
   logic        divide_error;
   modport source (output valid, output result_kind, output value, output divide_error,
                   input ready);
   modport sink   (input valid, input result_kind, input value, input divide_error,
                   output ready);
endinterface

### rtl/btpc_mul.sv
// Multi-cycle 64x64 multiplier keeping the low 64 product bits, 16 bits per cycle.
module btpc_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);
   logic [63:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + a_ff * {48'd0, b_ff[15:0]};
         a_in   = a_ff << 16;
         b_in   = b_ff >> 16;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

### rtl/btpc_div.sv
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
module btpc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] ud_ff, ud_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      ud_in   = ud_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]};
      if (start) begin
         // The most negative dividend stays 2^63 as an unsigned magnitude.
         ud_in   = divisor[63] ? (64'd0 - divisor) : divisor;
         quo_in  = dividend[63] ? (64'd0 - dividend) : dividend;
         rem_in  = '0;
         cnt_in  = '0;
         neg_in  = dividend[63] ^ divisor[63];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, ud_ff}) begin
            rem_in = 64'(trial - {1'b0, ud_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ud_ff  <= ud_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (64'd0 - quo_ff) : quo_ff;
endmodule

### rtl/btpc_datapath.sv
// Datapath: calibration registers, working registers, shared multiplier and divider.
module btpc_datapath #(
   parameter int unsigned RAW_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  btpc_pkg::cmd_type    cmd,
   output btpc_pkg::status_type status,
   input  logic                 req_kind,
   input  logic [19:0]          req_raw_sample,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_write_data,
   output logic                 out_kind,
   output logic [32:0]          out_value,
   output logic                 out_error
);
   logic [47:0] cal_t_ff;
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [15:0] cal_p9_ff;
   logic [31:0] fine_ff, tt_ff, val_ff, temp_out;
   logic [19:0] raw_ff;
   logic        kind_ff;
   logic [63:0] v1_ff, v2_ff, s_ff, w_ff, x_ff, p_ff, t_ff;
   logic [63:0] mul_a, mul_b, product, quotient, v1_new, raw64;
   logic [31:0] ta, tb, t1, t2, t3;
   logic        mul_done, div_done;
   logic        out_kind_ff, out_error_ff;
   logic [32:0] out_value_ff;

   btpc_mul u_mul (
      .clock(clock), .reset(reset), .start(cmd.mul_start),
      .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(product)
   );

   btpc_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(w_ff), .divisor(x_ff), .done(div_done), .quotient(quotient)
   );

   assign raw64  = {44'd0, raw_ff};
   assign t1     = {16'd0, cal_t_ff[15:0]};
   assign t2     = {{16{cal_t_ff[31]}}, cal_t_ff[31:16]};
   assign t3     = {{16{cal_t_ff[47]}}, cal_t_ff[47:32]};
   assign ta     = (32'(raw_ff) >> 3) - (t1 << 1);
   assign tb     = (32'(raw_ff) >> 4) - t1;
   assign v1_new = {{32{fine_ff[31]}}, fine_ff} - btpc_pkg::FINE_OFFSET;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         btpc_pkg::STEP_T0: begin mul_a = {32'd0, ta}; mul_b = {32'd0, t2}; end
         btpc_pkg::STEP_T1: begin mul_a = {32'd0, tb}; mul_b = {32'd0, tb}; end
         btpc_pkg::STEP_T2: begin mul_a = {32'd0, tt_ff}; mul_b = {32'd0, t3}; end
         btpc_pkg::STEP_P0: begin mul_a = v1_new; mul_b = v1_new; end
         btpc_pkg::STEP_P1: begin mul_a = s_ff; mul_b = btpc_pkg::sx16(cal_b_ff[31:16]); end
         btpc_pkg::STEP_P2: begin mul_a = v1_ff; mul_b = btpc_pkg::sx16(cal_b_ff[15:0]); end
         btpc_pkg::STEP_P3: begin mul_a = s_ff; mul_b = btpc_pkg::sx16(cal_a_ff[47:32]); end
         btpc_pkg::STEP_P4: begin mul_a = v1_ff; mul_b = btpc_pkg::sx16(cal_a_ff[31:16]); end
         btpc_pkg::STEP_P5: begin mul_a = x_ff; mul_b = {48'd0, cal_a_ff[15:0]}; end
         btpc_pkg::STEP_P6: begin
            mul_a = ((btpc_pkg::PRESS_BASE - raw64) << 31) - v2_ff;
            mul_b = btpc_pkg::SCALE_3125;
         end
         btpc_pkg::STEP_P7: begin
            mul_a = btpc_pkg::sx16(cal_p9_ff);
            mul_b = btpc_pkg::asr64(p_ff, 13);
         end
         btpc_pkg::STEP_P8: begin mul_a = t_ff; mul_b = btpc_pkg::asr64(p_ff, 13); end
         btpc_pkg::STEP_P9: begin mul_a = btpc_pkg::sx16(cal_b_ff[63:48]); mul_b = p_ff; end
         btpc_pkg::STEP_P10: begin
            mul_a = btpc_pkg::asr64(p_ff + v1_ff + v2_ff, 8)
                  + (btpc_pkg::sx16(cal_b_ff[47:32]) << 4);
            mul_b = btpc_pkg::SCALE_1000;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign temp_out = btpc_pkg::asr32((fine_ff << 2) + fine_ff + btpc_pkg::TEMP_ROUND, 8);

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff  <= '0;
         cal_a_ff  <= '0;
         cal_b_ff  <= '0;
         cal_p9_ff <= '0;
         fine_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               btpc_pkg::REG_CAL_TEMP:    cal_t_ff  <= csr_write_data[47:0];
               btpc_pkg::REG_CAL_PRESS_A: cal_a_ff  <= csr_write_data;
               btpc_pkg::REG_CAL_PRESS_B: cal_b_ff  <= csr_write_data;
               btpc_pkg::REG_CAL_P9:      cal_p9_ff <= csr_write_data[15:0];
               default: ;
            endcase
         end
         if (cmd.mul_wb && cmd.step == btpc_pkg::STEP_T0) begin
            fine_ff <= btpc_pkg::asr32(product[31:0], 11);
         end
         if (cmd.mul_wb && cmd.step == btpc_pkg::STEP_T2) begin
            fine_ff <= fine_ff + btpc_pkg::asr32(product[31:0], 14);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         raw_ff  <= req_raw_sample & 20'((64'd1 << RAW_BITS) - 64'd1);
      end
      if (cmd.mul_wb) begin
         case (cmd.step)
            btpc_pkg::STEP_T1: tt_ff <= btpc_pkg::asr32(product[31:0], 12);
            btpc_pkg::STEP_P0: begin v1_ff <= v1_new; s_ff <= product; end
            btpc_pkg::STEP_P1: v2_ff <= product;
            btpc_pkg::STEP_P2: v2_ff <= v2_ff + (product << 17)
                                       + (btpc_pkg::sx16(cal_a_ff[63:48]) << 35);
            btpc_pkg::STEP_P3: w_ff <= btpc_pkg::asr64(product, 8);
            btpc_pkg::STEP_P4: x_ff <= btpc_pkg::ONE_47 + w_ff + (product << 12);
            btpc_pkg::STEP_P5: x_ff <= btpc_pkg::asr64(product, 33);
            btpc_pkg::STEP_P6: w_ff <= product;
            btpc_pkg::STEP_P7: t_ff <= product;
            btpc_pkg::STEP_P8: v1_ff <= btpc_pkg::asr64(product, 25);
            btpc_pkg::STEP_P9: v2_ff <= btpc_pkg::asr64(product, 19);
            // The low 32 bits of the product shifted right by 8.
            btpc_pkg::STEP_P10: val_ff <= product[39:8];
            default: ;
         endcase
      end
      if (cmd.div_wb) begin
         p_ff <= quotient;
      end
      if (cmd.out_load) begin
         out_kind_ff  <= kind_ff;
         out_error_ff <= kind_ff && (x_ff == 64'd0);
         if (!kind_ff) begin
            out_value_ff <= {temp_out[31], temp_out};
         end else if (x_ff == 64'd0) begin
            out_value_ff <= '0;
         end else begin
            out_value_ff <= {1'b0, val_ff};
         end
      end
   end

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.den_zero = (x_ff == 64'd0);
   assign out_kind  = out_kind_ff;
   assign out_value = out_value_ff;
   assign out_error = out_error_ff;
endmodule

### rtl/btpc_ctrl.sv
// Controller: sequences the multiply and divide steps and owns the handshakes.
module btpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  btpc_pkg::status_type status,
   output btpc_pkg::cmd_type    cmd
);
   typedef enum logic [2:0] {IDLE, ISSUE, WAIT_MUL, WAIT_DIV, FINISH} state_type;

   state_type          state_ff;
   btpc_pkg::step_type step_ff;
   logic               out_valid_ff;

   always_comb begin
      cmd      = '0;
      cmd.step = step_ff;
      case (state_ff)
         IDLE: cmd.load = req_valid;
         ISSUE: begin
            if (step_ff == btpc_pkg::STEP_DIV) begin
               cmd.div_start = 1'b1;
            end else if (!(step_ff == btpc_pkg::STEP_P6 && status.den_zero)) begin
               cmd.mul_start = 1'b1;
            end
         end
         WAIT_MUL: cmd.mul_wb = status.mul_done;
         WAIT_DIV: cmd.div_wb = status.div_done;
         FINISH: cmd.out_load = !out_valid_ff || rsp_ready;
         default: cmd.load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= btpc_pkg::STEP_T0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == FINISH && (!out_valid_ff || rsp_ready)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  step_ff  <= req_kind ? btpc_pkg::STEP_P0 : btpc_pkg::STEP_T0;
                  state_ff <= ISSUE;
               end
            end
            ISSUE: begin
               if (step_ff == btpc_pkg::STEP_DIV) begin
                  state_ff <= WAIT_DIV;
               end else if (step_ff == btpc_pkg::STEP_P6 && status.den_zero) begin
                  // Zero divisor: skip the rest and report the error.
                  state_ff <= FINISH;
               end else begin
                  state_ff <= WAIT_MUL;
               end
            end
            WAIT_MUL: begin
               if (status.mul_done) begin
                  if (step_ff == btpc_pkg::STEP_T2 || step_ff == btpc_pkg::STEP_P10) begin
                     state_ff <= FINISH;
                  end else begin
                     step_ff  <= btpc_pkg::step_type'(step_ff + 4'd1);
                     state_ff <= ISSUE;
                  end
               end
            end
            WAIT_DIV: begin
               if (status.div_done) begin
                  step_ff  <= btpc_pkg::STEP_P7;
                  state_ff <= ISSUE;
               end
            end
            FINISH: begin
               if (!out_valid_ff || rsp_ready) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = out_valid_ff;
endmodule

### rtl/baro_temp_pressure_compensation.sv
// Each multiply step runs issue, four 16-bit partial products and write-back; the
// divide step runs issue, 64 quotient bits and write-back. One request at a time:
// the next can be taken in the cycle after the response registers, later while an
// unread response blocks the finish.
// Synchronous active-high reset clears calibration, fine temperature and control.
module baro_temp_pressure_compensation #(
   parameter int unsigned RAW_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   btpc_req_if.sink          req_chan,
   btpc_rsp_if.source        rsp_chan,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_write_data
);
   btpc_pkg::cmd_type    cmd;
   btpc_pkg::status_type status;

   btpc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_kind(req_chan.kind), .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .status(status), .cmd(cmd)
   );

   btpc_datapath #(.RAW_BITS(RAW_BITS)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_kind(req_chan.kind), .req_raw_sample(req_chan.raw_sample),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data),
      .out_kind(rsp_chan.result_kind), .out_value(rsp_chan.value),
      .out_error(rsp_chan.divide_error)
   );
endmodule

### rtl/btpc_checker.sv
// Port-level checker for the compensation block and its bind.
`include "baro_temp_pressure_compensation_macros.svh"

module btpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [32:0] rsp_value,
   input logic        rsp_divide_error
);
   `BTPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))
   `BTPC_ASSERT_NEXT(a_one_request, clock, reset, req_valid && req_ready, !req_ready)
   `BTPC_ASSERT_IMPLY(a_err_form, clock, reset, rsp_valid && rsp_divide_error, rsp_result_kind && rsp_value == 33'd0)
   `BTPC_ASSERT_IMPLY(a_press_unsigned, clock, reset, rsp_valid && rsp_result_kind, !rsp_value[32])
   `BTPC_ASSERT_IMPLY(a_temp_sext, clock, reset, rsp_valid && !rsp_result_kind, rsp_value[32] == rsp_value[31] && !rsp_divide_error)
endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_chan.valid), .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_result_kind(rsp_chan.result_kind), .rsp_value(rsp_chan.value),
   .rsp_divide_error(rsp_chan.divide_error)
);

### bench/tb.sv
// Self-checking testbench for the barometric temperature and pressure compensation block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 3000;
   localparam int SETTLE_LIMIT = 400;
   localparam int PHASE_ITEMS  = 400;

   typedef struct {
      logic        kind;
      logic [32:0] value;
      logic        err;
   } reading_type;

   typedef struct {
      bit          load_typical;
      logic        kind;
      logic [19:0] raw;
      bit          fixed;
      logic [32:0] value;
      logic        err;
   } row_type;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   btpc_req_if req ();
   btpc_rsp_if rsp ();

   baro_temp_pressure_compensation dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req),
      .rsp_chan       (rsp),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Mirror of the calibration registers and the fine temperature.
   logic [47:0] cal_temp;
   logic [63:0] cal_press_a;
   logic [63:0] cal_press_b;
   logic [15:0] cal_p9;
   logic [31:0] fine_temp;

   reading_type pending_readings[$];
   int          mismatches;
   int          results_seen;
   int          temp_count;
   int          press_count;
   int          div_error_count;
   int          send_idle_pct;
   int          stall_pct;
   int          hold_asks;
   int          hold_served;
   int          hold_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #24_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic reading_type compensate(input logic kind, input logic [19:0] raw);
      reading_type r;
      logic [31:0] t, t1, t2, t3, a, b, m, f, s;
      logic [63:0] ft, v1, v2, x, y, p, n, d, un, ud, q;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      r.kind = kind;
      r.err = 1'b0;
      r.value = '0;
      if (!kind) begin
         t  = {12'b0, raw};
         t1 = {16'b0, cal_temp[15:0]};
         t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
         t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
         a = (t >> 3) - (t1 << 1);
         b = (t >> 4) - t1;
         m = a * t2;
         f = $signed(m) >>> 11;
         m = b * b;
         m = $signed(m) >>> 12;
         m = m * t3;
         s = $signed(m) >>> 14;
         f = f + s;
         fine_temp = f;
         m = f * 32'd5 + 32'd128;
         s = $signed(m) >>> 8;
         r.value = {s[31], s};
      end else begin
         p1 = {48'b0, cal_press_a[15:0]};
         p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
         p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
         p4 = {{48{cal_press_a[63]}}, cal_press_a[63:48]};
         p5 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
         p6 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
         p7 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
         p8 = {{48{cal_press_b[63]}}, cal_press_b[63:48]};
         p9 = {{48{cal_p9[15]}}, cal_p9};
         ft = {{32{fine_temp[31]}}, fine_temp};
         v1 = ft - 64'd128000;
         v2 = v1 * v1 * p6;
         x = v1 * p5;
         v2 = v2 + (x << 17) + (p4 << 35);
         x = v1 * v1 * p3;
         x = $signed(x) >>> 8;
         y = v1 * p2;
         v1 = x + (y << 12);
         x = (64'd1 << 47) + v1;
         x = x * p1;
         v1 = $signed(x) >>> 33;
         if (v1 == 64'd0) begin
            r.err = 1'b1;
         end else begin
            p = 64'd1048576 - {44'b0, raw};
            n = ((p << 31) - v2) * 64'd3125;
            d = v1;
            un = n[63] ? -n : n;
            ud = d[63] ? -d : d;
            q = un / ud;
            if (n[63] ^ d[63]) begin
               q = -q;
            end
            x = $signed(q) >>> 13;
            y = p9 * x * x;
            v1 = $signed(y) >>> 25;
            y = p8 * q;
            v2 = $signed(y) >>> 19;
            x = q + v1 + v2;
            x = $signed(x) >>> 8;
            p = x + (p7 << 4);
            y = p * 64'd1000;
            y = $signed(y) >>> 8;
            r.value = {1'b0, y[31:0]};
         end
      end
      return r;
   endfunction

   task automatic write_cal(input logic [1:0] index, input logic [63:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = index;
      csr_write_data = data;
      case (index)
         btpc_pkg::REG_CAL_TEMP:    cal_temp = data[47:0];
         btpc_pkg::REG_CAL_PRESS_A: cal_press_a = data;
         btpc_pkg::REG_CAL_PRESS_B: cal_press_b = data;
         btpc_pkg::REG_CAL_P9:      cal_p9 = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic load_cal(input logic [47:0] t, input logic [63:0] a, input logic [63:0] b,
                           input logic [15:0] p9);
      // Upper bits beyond a register's width are filled with noise; the block drops them.
      write_cal(btpc_pkg::REG_CAL_TEMP, {16'($urandom_range(0, 16'hFFFF)), t});
      write_cal(btpc_pkg::REG_CAL_PRESS_A, a);
      write_cal(btpc_pkg::REG_CAL_PRESS_B, b);
      write_cal(btpc_pkg::REG_CAL_P9, {$urandom, 16'($urandom_range(0, 16'hFFFF)), p9});
   endtask

   task automatic load_typical_cal();
      load_cal({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
   endtask

   task automatic drain();
      wait (pending_readings.size() == 0);
      repeat (SETTLE_LIMIT) @(posedge clock);
      @(negedge clock);
   endtask

   // Drives one request and records what it must produce.
   task automatic send_request(input logic kind, input logic [19:0] raw, input bit fixed,
                               input logic [32:0] value, input logic err);
      reading_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid = 1'b0;
         req.kind = 1'($urandom_range(0, 1));
         req.raw_sample = 20'($urandom_range(0, 20'hFFFFF));
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.kind = kind;
      req.raw_sample = raw;
      do @(posedge clock); while (!req.ready);
      r = compensate(kind, raw);
      if (fixed) begin
         r.value = value;
         r.err = err;
      end
      pending_readings.push_back(r);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_word(input int style);
      case (style)
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   task automatic load_phase_cal(input int setting);
      int style;
      case (setting % 4)
         0: load_typical_cal();
         1: load_cal({$urandom, 16'($urandom_range(0, 16'hFFFF))}, {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom_range(0, 16'hFFFF)));
         default: begin
            style = (setting % 4 == 2) ? setting / 4 % 4 : $urandom_range(0, 4);
            load_cal({pick_word(style), pick_word(style), pick_word(style)},
                     {pick_word(style), pick_word(style), pick_word(style), pick_word(style)},
                     {pick_word(style), pick_word(style), pick_word(style), pick_word(style)},
                     pick_word(style));
         end
      endcase
   endtask

   // Response ready, with a long hold-off whenever the stimulus asks for one.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_served) begin
         rsp.ready <= 1'b0;
         hold_served <= hold_asks;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         results_seen++;
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected response: kind %0b value %h err %0b",
                        rsp.result_kind, rsp.value, rsp.divide_error);
            end
         end else begin
            want = pending_readings.pop_front();
            if (rsp.result_kind !== want.kind || rsp.value !== want.value ||
                rsp.divide_error !== want.err) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected kind %0b value %h err %0b, got %0b %h %0b",
                           want.kind, want.value, want.err,
                           rsp.result_kind, rsp.value, rsp.divide_error);
               end
            end
            if (want.kind) press_count++; else temp_count++;
            if (want.err) div_error_count++;
         end
      end
   end

   row_type directed[] = '{
      // All calibration is zero after reset: temperature reads zero, pressure hits the
      // zero divisor.
      '{0, 1'b0, 20'h00000, 1, 33'd0, 1'b0},
      '{0, 1'b0, 20'hFFFFF, 1, 33'd0, 1'b0},
      '{0, 1'b1, 20'h00000, 1, 33'd0, 1'b1},
      '{0, 1'b1, 20'hFFFFF, 1, 33'd0, 1'b1},
      '{1, 1'b1, 20'd415148, 0, 33'd0, 1'b0},
      '{0, 1'b0, 20'd519888, 0, 33'd0, 1'b0},
      '{0, 1'b1, 20'd415148, 0, 33'd0, 1'b0},
      '{0, 1'b1, 20'h00000, 0, 33'd0, 1'b0},
      '{0, 1'b1, 20'hFFFFF, 0, 33'd0, 1'b0},
      '{0, 1'b0, 20'h00000, 0, 33'd0, 1'b0},
      '{0, 1'b1, 20'h80000, 0, 33'd0, 1'b0},
      '{0, 1'b0, 20'hFFFFF, 0, 33'd0, 1'b0},
      '{0, 1'b1, 20'h55555, 0, 33'd0, 1'b0},
      '{0, 1'b0, 20'hAAAAA, 0, 33'd0, 1'b0},
      '{0, 1'b1, 20'hAAAAA, 0, 33'd0, 1'b0},
      '{0, 1'b0, 20'h55555, 0, 33'd0, 1'b0},
      '{0, 1'b1, 20'h7FFFF, 0, 33'd0, 1'b0}
   };

   initial begin
      int setting;
      logic kind;
      logic [19:0] raw;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = btpc_pkg::REG_CAL_TEMP;
      csr_write_data = '0;
      req.valid = 1'b0;
      req.kind = 1'b0;
      req.raw_sample = '0;
      rsp.ready = 1'b0;
      cal_temp = '0;
      cal_press_a = '0;
      cal_press_b = '0;
      cal_p9 = '0;
      fine_temp = '0;
      mismatches = 0;
      results_seen = 0;
      temp_count = 0;
      press_count = 0;
      div_error_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_asks = 0;
      hold_served = 0;
      hold_left = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].load_typical) begin
            req.valid = 1'b0;
            drain();
            load_typical_cal();
         end
         send_request(directed[i].kind, directed[i].raw, directed[i].fixed,
                      directed[i].value, directed[i].err);
      end
      req.valid = 1'b0;

      setting = 0;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 51 : (phase == 3) ? 30 : 0;
         stall_pct = (phase == 2) ? 51 : (phase == 3) ? 30 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 100 == 0) begin
               req.valid = 1'b0;
               drain();
               load_phase_cal(setting);
               setting++;
               // Hold the response side off while requests keep coming.
               if (phase == 0 && n == 100) hold_asks++;
            end
            kind = ($urandom_range(0, 99) < 55);
            case ($urandom_range(0, 9))
               0: raw = 20'h00000;
               1: raw = 20'hFFFFF;
               2: raw = 20'd1 << $urandom_range(0, 19);
               default: raw = 20'($urandom_range(0, 20'hFFFFF));
            endcase
            send_request(kind, raw, 0, 33'd0, 1'b0);
         end
      end
      req.valid = 1'b0;
      drain();

      $display("Covered %0d temperature and %0d pressure responses (%0d divide errors)",
               temp_count, press_count, div_error_count);
      $display("across %0d calibration settings and four handshake pacing modes", setting + 2);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches,
                  pending_readings.size());
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/btpc_pkg.sv
rtl/btpc_if.sv
rtl/btpc_mul.sv
rtl/btpc_div.sv
rtl/btpc_datapath.sv
rtl/btpc_ctrl.sv
rtl/baro_temp_pressure_compensation.sv
rtl/btpc_checker.sv
bench/tb.sv
